[hw/rtl/fhsc_pkg.sv]
// Shared types and constants for the floppy head seek controller.
package fhsc_pkg;

    localparam int TRACK_BITS = 8;
    localparam int DELAY_BITS = 20;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_ADDR_BITS = 2;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_SEEK  = 2'd1,
        OP_RECAL = 2'd2,
        OP_INVAL = 2'd3
    } fhsc_op_t;

    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_MAX_TRACK  = 2'd0,
        REG_HOME_LIMIT = 2'd1,
        REG_PULSE      = 2'd2,
        REG_SETTLE     = 2'd3
    } fhsc_reg_t;

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_HOME_TEST   = 3'd1,
        PH_HOME_PULSE  = 3'd2,
        PH_HOME_SETTLE = 3'd3,
        PH_SEEK_MOVE   = 3'd4,
        PH_SEEK_PULSE  = 3'd5,
        PH_SEEK_SETTLE = 3'd6
    } fhsc_phase_t;

    typedef struct packed {
        logic [7:0]  max_track;
        logic [7:0]  home_step_limit;
        logic [15:0] pulse_ticks;
        logic [19:0] settle_ticks;
    } fhsc_cfg_t;

    typedef struct packed {
        logic [TRACK_BITS-1:0] head_track;
        logic                  position_known;
        fhsc_phase_t           phase;
        logic [DELAY_BITS-1:0] delay_count;
        logic [7:0]            home_steps_done;
        logic [TRACK_BITS-1:0] goal_track;
        logic                  seek_after_home;
        logic                  direction_line;
    } fhsc_state_t;

    typedef struct packed {
        logic       track_valid;
        logic [7:0] current_track;
        logic       cmd_ok;
        logic       cmd_done;
        logic       busy_res;
        logic       dir_outward;
        logic       step_active;
    } fhsc_res_t;

endpackage

[hw/rtl/fhsc_cfg.sv]
// Configuration register bank.
module fhsc_cfg
    import fhsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output fhsc_cfg_t                cfg
);

    fhsc_cfg_t cfg_reg;
    fhsc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (fhsc_reg_t'(cfg_addr))
                REG_MAX_TRACK:  cfg_next.max_track       = cfg_wdata[7:0];
                REG_HOME_LIMIT: cfg_next.home_step_limit = cfg_wdata[7:0];
                REG_PULSE:      cfg_next.pulse_ticks     = cfg_wdata[15:0];
                REG_SETTLE:     cfg_next.settle_ticks    = cfg_wdata[19:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_track       <= 8'd79;
            cfg_reg.home_step_limit <= 8'd85;
            cfg_reg.pulse_ticks     <= 16'd4;
            cfg_reg.settle_ticks    <= 20'd3000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/fhsc_core.sv]
// Seek and recalibrate sequencer: state registers and per-word update.
module fhsc_core
    import fhsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  fhsc_cfg_t cfg,
    input  logic      in_fire,
    input  logic [1:0] operation,
    input  logic [7:0] target_track,
    input  logic      track0_sense,
    output fhsc_res_t res
);

    fhsc_state_t st_reg;
    fhsc_state_t st_next;
    logic        done;
    logic        ok;
    logic        do_home;
    logic        do_move;
    logic [DELAY_BITS-1:0] pulse_load;
    logic [DELAY_BITS-1:0] settle_load;
    logic        target_bad;

    assign pulse_load  = DELAY_BITS'(32'(cfg.pulse_ticks));
    assign settle_load = DELAY_BITS'(32'(cfg.settle_ticks));
    assign target_bad  = (target_track > cfg.max_track)
                       || ((32'(target_track) >> TRACK_BITS) != 32'd0);

    always_comb
    begin
        st_next = st_reg;
        done    = 1'b0;
        ok      = 1'b0;
        do_home = 1'b0;
        do_move = 1'b0;

        if (fhsc_op_t'(operation) == OP_TICK)
        begin
            case (st_reg.phase)
                PH_HOME_TEST: do_home = 1'b1;
                PH_SEEK_MOVE: do_move = 1'b1;
                PH_HOME_PULSE, PH_SEEK_PULSE:
                begin
                    if (st_reg.delay_count <= DELAY_BITS'(1))
                    begin
                        st_next.phase = (st_reg.phase == PH_HOME_PULSE) ?
                                        PH_HOME_SETTLE : PH_SEEK_SETTLE;
                        st_next.delay_count = settle_load;
                    end
                    else
                    begin
                        st_next.delay_count = st_reg.delay_count - DELAY_BITS'(1);
                    end
                end
                PH_HOME_SETTLE, PH_SEEK_SETTLE:
                begin
                    if (st_reg.delay_count != '0)
                    begin
                        st_next.delay_count = st_reg.delay_count - DELAY_BITS'(1);
                    end
                    else if (st_reg.phase == PH_HOME_SETTLE)
                    begin
                        st_next.phase = PH_HOME_TEST;
                        do_home = 1'b1;
                    end
                    else
                    begin
                        if (st_reg.direction_line)
                            st_next.head_track = st_reg.head_track - TRACK_BITS'(1);
                        else
                            st_next.head_track = st_reg.head_track + TRACK_BITS'(1);
                        st_next.phase = PH_SEEK_MOVE;
                        do_move = 1'b1;
                    end
                end
                default: st_next.phase = PH_IDLE;
            endcase
        end
        else if (st_reg.phase == PH_IDLE)
        begin
            case (fhsc_op_t'(operation))
                OP_SEEK:
                begin
                    if (target_bad)
                    begin
                        done = 1'b1;
                    end
                    else
                    begin
                        st_next.goal_track = TRACK_BITS'(target_track);
                        if (!st_reg.position_known)
                        begin
                            st_next.seek_after_home = 1'b1;
                            st_next.home_steps_done = 8'd0;
                            st_next.direction_line  = 1'b1;
                            st_next.phase           = PH_HOME_TEST;
                        end
                        else
                        begin
                            st_next.phase = PH_SEEK_MOVE;
                        end
                    end
                end
                OP_RECAL:
                begin
                    st_next.seek_after_home = 1'b0;
                    st_next.home_steps_done = 8'd0;
                    st_next.direction_line  = 1'b1;
                    st_next.phase           = PH_HOME_TEST;
                end
                default: st_next.position_known = 1'b0;
            endcase
        end

        // home test: track zero seen, give up, or another outward step
        if (do_home)
        begin
            if (track0_sense)
            begin
                st_next.head_track     = '0;
                st_next.position_known = 1'b1;
                if (st_next.seek_after_home)
                begin
                    st_next.seek_after_home = 1'b0;
                    st_next.phase = PH_SEEK_MOVE;
                    do_move = 1'b1;
                end
                else
                begin
                    st_next.phase = PH_IDLE;
                    done = 1'b1;
                    ok   = 1'b1;
                end
            end
            else if (st_next.home_steps_done >= cfg.home_step_limit)
            begin
                st_next.position_known  = 1'b0;
                st_next.phase           = PH_IDLE;
                st_next.seek_after_home = 1'b0;
                done = 1'b1;
            end
            else
            begin
                st_next.home_steps_done = st_next.home_steps_done + 8'd1;
                st_next.direction_line  = 1'b1;
                st_next.phase           = PH_HOME_PULSE;
                st_next.delay_count     = pulse_load;
            end
        end

        // seek move: step toward goal, or finish with optional zero check
        if (do_move)
        begin
            if (st_next.head_track < st_next.goal_track)
            begin
                st_next.direction_line = 1'b0;
                st_next.phase          = PH_SEEK_PULSE;
                st_next.delay_count    = pulse_load;
            end
            else if (st_next.head_track > st_next.goal_track)
            begin
                st_next.direction_line = 1'b1;
                st_next.phase          = PH_SEEK_PULSE;
                st_next.delay_count    = pulse_load;
            end
            else
            begin
                st_next.phase           = PH_IDLE;
                st_next.seek_after_home = 1'b0;
                done = 1'b1;
                if (st_next.goal_track == '0 && !track0_sense)
                begin
                    st_next.position_known = 1'b0;
                end
                else
                begin
                    ok = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.head_track      <= '0;
            st_reg.position_known  <= 1'b0;
            st_reg.phase           <= PH_IDLE;
            st_reg.delay_count     <= '0;
            st_reg.home_steps_done <= 8'd0;
            st_reg.goal_track      <= '0;
            st_reg.seek_after_home <= 1'b0;
            st_reg.direction_line  <= 1'b0;
        end
        else if (in_fire)
        begin
            st_reg <= st_next;
        end
    end

    always_comb
    begin
        res.step_active   = (st_next.phase == PH_HOME_PULSE)
                          || (st_next.phase == PH_SEEK_PULSE);
        res.dir_outward   = st_next.direction_line;
        res.busy_res      = (st_next.phase != PH_IDLE);
        res.cmd_done      = done;
        res.cmd_ok        = done & ok;
        res.current_track = 8'(st_next.head_track);
        res.track_valid   = st_next.position_known;
    end

endmodule

[hw/rtl/fhsc_obuf.sv]
// Result register with valid flag; frees the input side when empty or draining.
module fhsc_obuf
    import fhsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  fhsc_res_t res,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output fhsc_res_t out_res
);

    logic      valid_reg;
    logic      valid_next;
    fhsc_res_t res_reg;

    assign in_ready   = !valid_reg || out_ready;
    assign valid_next = in_fire || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            res_reg <= res;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

[hw/rtl/floppy_head_seek_controller.sv]
// Top level of the floppy head seek and recalibrate controller.
//
// Input words on s_*: s_tuser carries the operation (tick, seek, recalibrate,
// invalidate); s_tdata carries the seek target and the track-zero sense.
// Every input word yields exactly one result word on m_*, showing the step
// and direction lines, busy, command completion and status, and the believed
// head track and whether it is known.
// Results are registered: a word accepted at one edge appears on m_* after it.
// Throughput is one word per cycle while intake is not blocked; the state update
// and result are formed in one pass of logic ahead of the result register.
// When m_tready is low the result is held and s_tready drops only while the
// result register is full; a waiting result does not block intake once the
// receiver takes it in the same cycle.
// Reset clears the head state (position unknown, idle, direction inward) and
// loads the register defaults: max track 79, step limit 85, pulse 4 ticks,
// settle 3000 ticks. cfg_* writes land on any edge with cfg_we high and
// must only be made while idle.
module floppy_head_seek_controller
    import fhsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,  // [7:0] target_track, [8] track0_sense
    input  logic [1:0]               s_tuser,  // [1:0] operation
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // [0] step_active, [1] dir_outward, [2] busy_res, [3] cmd_done, [4] cmd_ok,
    // [12:5] current_track, [13] track_valid
    output logic [15:0]              m_tdata,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

    fhsc_cfg_t cfg;
    fhsc_res_t res;
    fhsc_res_t out_res;
    logic      in_ready;
    logic      in_fire;

    assign s_tready = in_ready;
    assign in_fire  = s_tvalid && in_ready;

    fhsc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    fhsc_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_fire      (in_fire),
        .operation    (s_tuser),
        .target_track (s_tdata[7:0]),
        .track0_sense (s_tdata[8]),
        .res          (res)
    );

    fhsc_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .res       (res),
        .in_ready  (in_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {2'b00, out_res};

endmodule

[hw/rtl/fhsc_chk.sv]
// Port-level checker for the seek controller, bound to the top level.
module fhsc_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted word gave no result");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled with room in result register");

    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[4] |-> m_tdata[3])
        else $error("ok flag without done");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[2] && !m_tdata[3])
        else $error("step pulse outside a busy command");

endmodule

bind floppy_head_seek_controller fhsc_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
